[rtl/nrbp_pkg.sv]
// shared types, constants and code builder for the nibble run-length bit packer
// no dependencies; imported by every module of the block
package nrbp_pkg;

  localparam int SYM_W      = 4;
  localparam int RUN_W      = 6;
  localparam int CODE_W     = 10;
  localparam int CODE_LEN_W = 4;
  localparam int CHUNK_W    = 2 * CODE_W;
  localparam int LEN_W      = 5;
  localparam int PEND_W     = 7;
  localparam int ACC_W      = CHUNK_W + PEND_W;
  localparam int CNT_W      = 5;
  localparam int TOTAL_W    = 19;
  localparam int BYTE_W     = 8;
  localparam int VALID_W    = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [RUN_W-1:0]      RUN_CAP   = 6'd33;
  localparam logic [CODE_LEN_W-1:0] LEN_SHORT = 4'd5;
  localparam logic [CODE_LEN_W-1:0] LEN_LONG  = 4'd10;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX = 19'h7FFFF;
  localparam logic [CNT_W-1:0]      BYTE_BITS = 5'd8;

  // one queue entry: the codes that one symbol causes, left-aligned
  typedef struct packed {
    logic [CHUNK_W-1:0] bits;
    logic [LEN_W-1:0]   len;
    logic               last;
  } chunk_t;

  // code of a run, left-aligned in CODE_W bits
  function automatic logic [CODE_W-1:0] run_code(input logic [SYM_W-1:0] sym,
                                                 input logic [RUN_W-1:0] run);
    logic [RUN_W-1:0] len_m2;
    len_m2 = run - 6'd2;
    if (run < 6'd2) begin
      run_code = {1'b0, sym, 5'b0};
    end else begin
      run_code = {1'b1, sym, len_m2[4:0]};
    end
  endfunction

  function automatic logic [CODE_LEN_W-1:0] run_len(input logic [RUN_W-1:0] run);
    run_len = (run < 6'd2) ? LEN_SHORT : LEN_LONG;
  endfunction

endpackage

[rtl/nrbp_front.sv]
// front end: tracks the current run and turns each symbol that closes a run or ends the stream into a chunk of codes
// depends on nrbp_pkg
module nrbp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic [3:0]            in_sym,
  input  logic                  in_last,
  output logic                  push,
  output nrbp_pkg::chunk_t      push_data
);
  import nrbp_pkg::*;

  logic [SYM_W-1:0] prev_symbol_r, prev_symbol_nxt;
  logic [RUN_W-1:0] run_length_r, run_length_nxt;
  logic             have_prev_r, have_prev_nxt;

  logic [SYM_W-1:0]      cur_sym;
  logic [RUN_W-1:0]      cur_run;
  logic                  a_en;
  logic [CODE_W-1:0]     a_code, b_code;
  logic [CODE_LEN_W-1:0] a_len, b_len;
  logic [CHUNK_W-1:0]    b_shift;

  // run tracking and code selection
  always_comb begin
    a_en    = 1'b0;
    cur_sym = in_sym;
    cur_run = 6'd1;
    if (have_prev_r && in_sym == prev_symbol_r && run_length_r < RUN_CAP) begin
      cur_sym = prev_symbol_r;
      cur_run = run_length_r + 6'd1;
    end else if (have_prev_r) begin
      a_en = 1'b1;
    end
    a_code = a_en ? run_code(prev_symbol_r, run_length_r) : '0;
    a_len  = a_en ? run_len(run_length_r) : '0;
    b_code = in_last ? run_code(cur_sym, cur_run) : '0;
    b_len  = in_last ? run_len(cur_run) : '0;
    b_shift = {b_code, {CODE_W{1'b0}}} >> a_len;

    push_data.bits = {a_code, {CODE_W{1'b0}}} | b_shift;
    push_data.len  = {1'b0, a_len} + {1'b0, b_len};
    push_data.last = in_last;
    push           = in_fire && (a_en || in_last);

    prev_symbol_nxt = prev_symbol_r;
    run_length_nxt  = run_length_r;
    have_prev_nxt   = have_prev_r;
    if (in_fire) begin
      if (in_last) begin
        prev_symbol_nxt = '0;
        run_length_nxt  = '0;
        have_prev_nxt   = 1'b0;
      end else begin
        prev_symbol_nxt = cur_sym;
        run_length_nxt  = cur_run;
        have_prev_nxt   = 1'b1;
      end
    end
  end

  // run state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_symbol_r <= '0;
      run_length_r  <= '0;
      have_prev_r   <= 1'b0;
    end else begin
      prev_symbol_r <= prev_symbol_nxt;
      run_length_r  <= run_length_nxt;
      have_prev_r   <= have_prev_nxt;
    end
  end

endmodule

[rtl/nrbp_fifo.sv]
// short chunk queue between the front end and the bit packer
// depends on nrbp_pkg
module nrbp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nrbp_pkg::chunk_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output nrbp_pkg::chunk_t  pop_data
);
  import nrbp_pkg::*;

  chunk_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/nrbp_back.sv]
// back end: merges chunks into a bit accumulator and sends out one byte per transfer
// depends on nrbp_pkg
module nrbp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  nrbp_pkg::chunk_t             q_data,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [nrbp_pkg::BYTE_W-1:0]  out_byte,
  output logic [nrbp_pkg::VALID_W-1:0] out_valid_bits,
  output logic                         out_end,
  output logic [nrbp_pkg::TOTAL_W-1:0] out_total
);
  import nrbp_pkg::*;

  logic [ACC_W-1:0]   acc_r, acc_nxt, acc_e;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_e;
  logic               last_r, last_nxt, last_e;
  logic [TOTAL_W-1:0] total_r, total_nxt, total_e;
  logic [TOTAL_W:0]   total_sum;

  logic               oval_r, oval_nxt;
  logic [BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic [VALID_W-1:0] ovb_r, ovb_nxt;
  logic               oend_r, oend_nxt;
  logic [TOTAL_W-1:0] otot_r, otot_nxt;

  logic need_emit, out_free, emit, final_byte;

  assign out_tvalid     = oval_r;
  assign out_byte       = obyte_r;
  assign out_valid_bits = ovb_r;
  assign out_end        = oend_r;
  assign out_total      = otot_r;

  always_comb begin
    // byte emission from the accumulator
    need_emit  = last_r || (cnt_r >= BYTE_BITS);
    out_free   = !oval_r || out_tready;
    emit       = need_emit && out_free;
    final_byte = last_r && (cnt_r <= BYTE_BITS);

    acc_e   = acc_r;
    cnt_e   = cnt_r;
    last_e  = last_r;
    total_e = total_r;
    if (emit) begin
      if (final_byte) begin
        acc_e   = '0;
        cnt_e   = '0;
        last_e  = 1'b0;
        total_e = '0;
      end else begin
        acc_e = acc_r << BYTE_W;
        cnt_e = cnt_r - BYTE_BITS;
      end
    end

    // merge the next chunk once less than a full byte is left to send
    q_pop     = q_not_empty && !last_e && (cnt_e < BYTE_BITS);
    total_sum = {1'b0, total_e} + (TOTAL_W+1)'(q_data.len);
    acc_nxt   = acc_e;
    cnt_nxt   = cnt_e;
    last_nxt  = last_e;
    total_nxt = total_e;
    if (q_pop) begin
      acc_nxt   = acc_e | ({q_data.bits, {PEND_W{1'b0}}} >> cnt_e[2:0]);
      cnt_nxt   = cnt_e + q_data.len;
      last_nxt  = q_data.last;
      total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    end

    // output register
    oval_nxt  = oval_r;
    obyte_nxt = obyte_r;
    ovb_nxt   = ovb_r;
    oend_nxt  = oend_r;
    otot_nxt  = otot_r;
    if (emit) begin
      oval_nxt  = 1'b1;
      obyte_nxt = acc_r[ACC_W-1 -: BYTE_W];
      ovb_nxt   = final_byte ? cnt_r[VALID_W-1:0] : VALID_W'(BYTE_W);
      oend_nxt  = final_byte;
      otot_nxt  = final_byte ? total_r : '0;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      total_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      total_r <= total_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    ovb_r   <= ovb_nxt;
    oend_r  <= oend_nxt;
    otot_r  <= otot_nxt;
  end

endmodule

[rtl/nibble_rle_bit_packer_top.sv]
// nibble run-length coder with msb-first byte packing, top level
// path: a byte that a symbol completes passes the queue write, the accumulator merge and the
// output register before out_tvalid rises, when queue and packer are idle
// throughput: one symbol per cycle while the queue has room; the packer sends one byte per
// cycle unless out_tready holds it back, and takes no new chunk until under a byte remains
// reset: synchronous, active low rst_n; run state, queue pointers, accumulator, out_tvalid clear
module nibble_rle_bit_packer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [nrbp_pkg::IN_TDATA_W-1:0]    in_tdata,   // [3:0] symbol, [7:4] zero
  input  logic                               in_tlast,   // last_symbol
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] out_byte, [11:8] valid_bits, [30:12] total_bits
  output logic [nrbp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast   // stream_end
);
  import nrbp_pkg::*;

  logic               in_fire;
  logic               push, full, pop, not_empty;
  chunk_t             push_data, pop_data;
  logic [BYTE_W-1:0]  out_byte;
  logic [VALID_W-1:0] valid_bits;
  logic [TOTAL_W-1:0] total_bits;

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  // run tracking
  nrbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_sym    (in_tdata[SYM_W-1:0]),
    .in_last   (in_tlast),
    .push      (push),
    .push_data (push_data)
  );

  // chunk queue
  nrbp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  // bit packer
  nrbp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (not_empty),
    .q_data         (pop_data),
    .q_pop          (pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_byte       (out_byte),
    .out_valid_bits (valid_bits),
    .out_end        (out_tlast),
    .out_total      (total_bits)
  );

  assign out_tdata = {1'b0, total_bits, valid_bits, out_byte};

endmodule
